// ----- rtl/websocket_frame_deframer_defines.svh -----
// Assertion macros for the WebSocket frame deframer.
// Included by the top level; depends on nothing else.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define WSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wsd_pkg.sv -----
// Shared types and constants of the WebSocket frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned DECL_W   = 64;
  localparam int unsigned OPCODE_W = 4;
  localparam int unsigned KEY_W    = 32;

  // Output tdata layout, lowest bit first.
  localparam int unsigned TD_DATA_LO  = 0;
  localparam int unsigned TD_FIN      = 8;
  localparam int unsigned TD_RSV1     = 9;
  localparam int unsigned TD_RSV2     = 10;
  localparam int unsigned TD_RSV3     = 11;
  localparam int unsigned TD_OPC_LO   = 12;
  localparam int unsigned TD_LEN_LO   = 16;
  localparam int unsigned TD_TRUNC    = 48;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd65536;

  // Result kinds, carried on tuser.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  typedef struct packed {
    logic                kind;
    logic [BYTE_W-1:0]   data_byte;
    logic                fin_bit;
    logic                rsv_one;
    logic                rsv_two;
    logic                rsv_three;
    logic [OPCODE_W-1:0] frame_opcode;
    logic [LEN_W-1:0]    payload_length;
    logic                last;
    logic                truncated;
  } result_t;

  function automatic logic [OUT_TDATA_W-1:0] pack_tdata(input result_t r);
    logic [OUT_TDATA_W-1:0] d;
    d = '0;
    d[TD_DATA_LO +: BYTE_W]  = r.data_byte;
    d[TD_FIN]                = r.fin_bit;
    d[TD_RSV1]               = r.rsv_one;
    d[TD_RSV2]               = r.rsv_two;
    d[TD_RSV3]               = r.rsv_three;
    d[TD_OPC_LO +: OPCODE_W] = r.frame_opcode;
    d[TD_LEN_LO +: LEN_W]    = r.payload_length;
    d[TD_TRUNC]              = r.truncated;
    return d;
  endfunction

endpackage

// ----- rtl/wsd_in_reg.sv -----
// Input register of the WebSocket frame deframer: holds one received byte.
// Depends on wsd_pkg.
module wsd_in_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [wsd_pkg::BYTE_W-1:0] s_tdata,
  input  logic                       advance,
  output logic                       byte_valid,
  output logic [wsd_pkg::BYTE_W-1:0] byte_q
);
  import wsd_pkg::*;

  // Take a new byte when empty or when the held one moves on this cycle.
  assign s_tready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      byte_q <= s_tdata;
    end
  end

endmodule

// ----- rtl/wsd_parser.sv -----
// Frame parser of the WebSocket frame deframer: header decode, length,
// mask key, unmasking and skip of clipped bytes. Depends on wsd_pkg.
module wsd_parser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [wsd_pkg::LEN_W-1:0]  cfg_wr_data,
  input  logic                       byte_valid,
  input  logic [wsd_pkg::BYTE_W-1:0] byte_q,
  input  logic                       advance,
  output logic                       needs_out,
  output logic                       res_valid,
  output wsd_pkg::result_t           res
);
  import wsd_pkg::*;

  localparam logic [2:0] PH_HDR0 = 3'd0;
  localparam logic [2:0] PH_HDR1 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_SKIP = 3'd5;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  logic [LEN_W-1:0]  max_len;
  logic [2:0]        phase, phase_next;
  logic [BYTE_W-1:0] header_bits, header_bits_next;
  logic              mask_flag, mask_flag_next;
  logic [DECL_W-1:0] length_accum, length_accum_next;
  logic [3:0]        field_cnt, field_cnt_next;
  logic [KEY_W-1:0]  mask_key, mask_key_next;
  logic [1:0]        key_index, key_index_next;
  logic [LEN_W-1:0]  remaining, remaining_next;
  logic [LEN_W-1:0]  clipped, clipped_next;
  logic [DECL_W-1:0] skip_cnt, skip_cnt_next;
  logic              trunc, trunc_next;

  logic [DECL_W-1:0] declared;
  logic              over;
  logic [LEN_W-1:0]  clip_len;
  logic              emit;
  logic [BYTE_W-1:0] key_byte;
  logic [3:0]        field_dec;
  logic              data_last;

  assign field_dec = field_cnt - 4'd1;

  // Clip the declared length against the register at header completion.
  always_comb begin
    declared = length_accum;
    unique case (phase)
      PH_HDR1: declared = {{(DECL_W-7){1'b0}}, byte_q[6:0]};
      PH_EXT:  declared = {length_accum[DECL_W-BYTE_W-1:0], byte_q};
      default: declared = length_accum;
    endcase
  end

  assign over     = (declared[DECL_W-1:LEN_W] != '0) || (declared[LEN_W-1:0] > max_len);
  assign clip_len = over ? max_len : declared[LEN_W-1:0];

  always_comb begin
    key_byte = mask_key[31:24];
    unique case (key_index)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      2'd3: key_byte = mask_key[7:0];
      default: key_byte = mask_key[31:24];
    endcase
  end

  assign data_last = (remaining == {{(LEN_W-1){1'b0}}, 1'b1});

  always_comb begin
    phase_next        = phase;
    header_bits_next  = header_bits;
    mask_flag_next    = mask_flag;
    length_accum_next = length_accum;
    field_cnt_next    = field_cnt;
    mask_key_next     = mask_key;
    key_index_next    = key_index;
    remaining_next    = remaining;
    clipped_next      = clipped;
    skip_cnt_next     = skip_cnt;
    trunc_next        = trunc;
    emit              = 1'b0;
    needs_out         = 1'b0;

    unique case (phase)
      PH_HDR1: begin
        mask_flag_next    = byte_q[7];
        length_accum_next = '0;
        mask_key_next     = '0;
        key_index_next    = 2'd0;
        if (byte_q[6:0] == LEN_EXT16) begin
          field_cnt_next = 4'd2;
          phase_next     = PH_EXT;
        end else if (byte_q[6:0] == LEN_EXT64) begin
          field_cnt_next = 4'd8;
          phase_next     = PH_EXT;
        end else begin
          length_accum_next = declared;
          if (byte_q[7]) begin
            field_cnt_next = 4'd4;
            phase_next     = PH_KEY;
          end else begin
            emit = 1'b1;
          end
        end
      end
      PH_EXT: begin
        length_accum_next = declared;
        field_cnt_next    = field_dec;
        if (field_dec == 4'd0) begin
          if (mask_flag) begin
            field_cnt_next = 4'd4;
            phase_next     = PH_KEY;
          end else begin
            emit = 1'b1;
          end
        end
      end
      PH_KEY: begin
        mask_key_next  = {mask_key[KEY_W-BYTE_W-1:0], byte_q};
        field_cnt_next = field_dec;
        if (field_dec == 4'd0) begin
          emit = 1'b1;
        end
      end
      PH_DATA: begin
        needs_out      = 1'b1;
        key_index_next = key_index + 2'd1;
        remaining_next = remaining - {{(LEN_W-1){1'b0}}, 1'b1};
        if (data_last) begin
          phase_next = (skip_cnt != '0) ? PH_SKIP : PH_HDR0;
        end
      end
      PH_SKIP: begin
        skip_cnt_next = skip_cnt - {{(DECL_W-1){1'b0}}, 1'b1};
        if (skip_cnt == {{(DECL_W-1){1'b0}}, 1'b1}) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        header_bits_next = byte_q;
        phase_next       = PH_HDR1;
      end
    endcase

    // Header complete: latch the clipped length and set up payload/skip.
    if (emit) begin
      needs_out      = 1'b1;
      clipped_next   = clip_len;
      trunc_next     = over;
      skip_cnt_next  = declared - {{(DECL_W-LEN_W){1'b0}}, clip_len};
      remaining_next = clip_len;
      key_index_next = 2'd0;
      if (clip_len != '0) begin
        phase_next = PH_DATA;
      end else begin
        phase_next = over ? PH_SKIP : PH_HDR0;
      end
    end
  end

  assign res_valid = byte_valid && needs_out;

  always_comb begin
    res.kind           = (phase == PH_DATA) ? KIND_DATA : KIND_HEADER;
    res.data_byte      = (phase == PH_DATA) ? (byte_q ^ key_byte) : '0;
    res.fin_bit        = header_bits[7];
    res.rsv_one        = header_bits[6];
    res.rsv_two        = header_bits[5];
    res.rsv_three      = header_bits[4];
    res.frame_opcode   = header_bits[OPCODE_W-1:0];
    res.payload_length = clipped_next;
    res.last           = (phase == PH_DATA) ? data_last : (clip_len == '0);
    res.truncated      = trunc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      header_bits  <= '0;
      mask_flag    <= 1'b0;
      length_accum <= '0;
      field_cnt    <= '0;
      mask_key     <= '0;
      key_index    <= '0;
      remaining    <= '0;
      clipped      <= '0;
      skip_cnt     <= '0;
      trunc        <= 1'b0;
    end else if (advance) begin
      phase        <= phase_next;
      header_bits  <= header_bits_next;
      mask_flag    <= mask_flag_next;
      length_accum <= length_accum_next;
      field_cnt    <= field_cnt_next;
      mask_key     <= mask_key_next;
      key_index    <= key_index_next;
      remaining    <= remaining_next;
      clipped      <= clipped_next;
      skip_cnt     <= skip_cnt_next;
      trunc        <= trunc_next;
    end
  end

endmodule

// ----- rtl/wsd_out_reg.sv -----
// Result register of the WebSocket frame deframer: holds one result
// until the receiver takes it. Depends on wsd_pkg.
module wsd_out_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  wsd_pkg::result_t                res,
  output logic                            out_free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [wsd_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tuser,
  output logic                            m_tlast
);
  import wsd_pkg::*;

  result_t held;

  // Free when empty or when the held result leaves this cycle.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign m_tdata = pack_tdata(held);
  assign m_tuser = held.kind;
  assign m_tlast = held.last;

endmodule

// ----- rtl/websocket_frame_deframer.sv -----
// WebSocket frame deframer (receive side with unmasking), top level.
// Depends on wsd_pkg, wsd_in_reg, wsd_parser, wsd_out_reg and the defines header.
//
// Usage:
//   s_* carries the received connection bytes, one byte per transfer (s_tdata).
//   m_* carries results: tuser = 0 for a frame header, 1 for a payload byte.
//   m_tlast marks the final payload byte, or a header whose payload is empty.
//   cfg_wr_en/cfg_wr_data write max_payload_len; write it only while idle.
//   Frames declaring more than max_payload_len bytes are clipped: the header
//   reports the clipped length with truncated set, and excess bytes are dropped.
// Timing:
//   A byte is parsed from the input register in the cycle after its transfer,
//   and its result loads into the output register when the byte advances,
//   raising m_tvalid. One byte per cycle unless a result-producing byte stalls.
// Reset (rst, synchronous): parser returns to expecting a first header byte,
//   all state clears, max_payload_len returns to 65536, no result is pending.
// Stall: when m_tready is low the output register holds its result; a byte that
//   would produce a result then holds in the input register and s_tready drops.
//   Bytes that produce no result (header, length and key bytes but the last, and
//   skipped bytes) keep flowing while the output register is full.
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: max_payload_len
  input  logic                            cfg_wr_en,
  input  logic [wsd_pkg::LEN_W-1:0]       cfg_wr_data,
  // Received bytes
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [wsd_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
  // Results
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] data_byte, [8] fin_bit, [9] rsv_one, [10] rsv_two, [11] rsv_three,
  // [15:12] frame_opcode, [47:16] payload_length, [48] truncated, [55:49] zero
  output logic [wsd_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tuser,   // [0] kind
  output logic                            m_tlast    // last
);
  import wsd_pkg::*;

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_q;
  logic              advance;
  logic              needs_out;
  logic              res_valid;
  logic              out_free;
  result_t           res;

  // Advance the held byte when its result (if any) has room to land.
  assign advance = byte_valid && (out_free || !needs_out);

  wsd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_valid  (byte_valid),
    .byte_q      (byte_q),
    .advance     (advance),
    .needs_out   (needs_out),
    .res_valid   (res_valid),
    .res         (res)
  );

  wsd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .out_free (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // A held byte that cannot move keeps its value.
  `WSD_ASSERT_NEXT(a_in_hold, clk, rst, byte_valid && !advance,
    byte_valid && $stable(byte_q), "input byte lost while stalled")

  // A header is marked last exactly when its clipped payload is empty.
  `WSD_ASSERT_NOW(a_hdr_last, clk, rst, m_tvalid && (m_tuser == KIND_HEADER),
    m_tlast == (m_tdata[TD_LEN_LO +: LEN_W] == '0), "header last flag wrong")

  // Payload bytes only belong to frames with a nonzero clipped length.
  `WSD_ASSERT_NOW(a_data_len, clk, rst, m_tvalid && (m_tuser == KIND_DATA),
    m_tdata[TD_LEN_LO +: LEN_W] != '0, "payload byte in empty frame")

endmodule
